>>> rtl/vwc_pkg.sv
// Shared constants, types and helper functions of the valid-window correlation unit.
package vwc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_WIN     = 3;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = 10;
    localparam int DIM_W       = 11;
    localparam int WIN_W       = 2;
    localparam int COEF_ROW_W  = MAX_WIN * SAMPLE_W;
    localparam int SUM_W       = 35;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int PART_W      = PROD_W + 2;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int LINE_W      = (MAX_WIN - 1) * SAMPLE_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2    = 3'd6;

    typedef logic [MAX_WIN-1:0][MAX_WIN-1:0][SAMPLE_W-1:0] win_t;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [WIN_W-1:0] window_rows;
        logic [WIN_W-1:0] window_cols;
        win_t             coef;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;
    } meta_t;

    typedef struct packed {
        win_t  win;
        meta_t meta;
    } job_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > hi)
            begin
                r = hi;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

    function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = WIN_W'(1);
            end
            else if (v > WIN_W'(MAX_WIN))
            begin
                r = WIN_W'(MAX_WIN);
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/vwc_ram.sv
// Generic single-write, single-read RAM with registered read data (old data on collision).
module vwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

>>> rtl/vwc_front.sv
// Front end: sample intake, raster counters, line store and window register array.
module vwc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vwc_pkg::cfg_t              cfg,
    input  logic                       push,
    input  logic signed [vwc_pkg::SAMPLE_W-1:0] sample,
    output logic                       full,
    input  logic [vwc_pkg::QCNT_W-1:0] q_count,
    output logic                       q_push,
    output vwc_pkg::job_t              q_data
);

    logic [vwc_pkg::CNT_W-1:0]    col_reg;
    logic [vwc_pkg::CNT_W-1:0]    col_next;
    logic [vwc_pkg::CNT_W-1:0]    row_reg;
    logic [vwc_pkg::CNT_W-1:0]    row_next;
    logic                         s1_valid_reg;
    logic                         s1_emit_reg;
    logic [vwc_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic [vwc_pkg::ADDR_W-1:0]   s1_addr_reg;
    vwc_pkg::meta_t               s1_meta_reg;
    logic                         byp_hit_reg;
    logic [vwc_pkg::LINE_W-1:0]   byp_data_reg;
    vwc_pkg::win_t                win_reg;
    vwc_pkg::win_t                win_next;

    logic [vwc_pkg::DIM_W-1:0]    w_eff;
    logic [vwc_pkg::DIM_W-1:0]    h_eff;
    logic [vwc_pkg::WIN_W-1:0]    wr_eff;
    logic [vwc_pkg::WIN_W-1:0]    wc_eff;
    logic [vwc_pkg::DIM_W-1:0]    col_p1;
    logic [vwc_pkg::DIM_W-1:0]    row_p1;
    logic                         emit;
    logic                         row_end;
    vwc_pkg::meta_t               meta;
    logic                         accept;
    logic [vwc_pkg::ADDR_W-1:0]   rd_addr;
    logic [vwc_pkg::LINE_W-1:0]   ram_rdata;
    logic [vwc_pkg::LINE_W-1:0]   lines;
    logic [vwc_pkg::MAX_WIN-1:0][vwc_pkg::SAMPLE_W-1:0] colv;
    logic [vwc_pkg::LINE_W-1:0]   wr_data;
    logic [vwc_pkg::QCNT_W:0]     occupancy;

    always_comb
    begin
        w_eff   = vwc_pkg::clamp_dim(cfg.image_width, vwc_pkg::DIM_W'(vwc_pkg::MAX_WIDTH));
        h_eff   = vwc_pkg::clamp_dim(cfg.image_height, vwc_pkg::DIM_W'(vwc_pkg::MAX_HEIGHT));
        wr_eff  = vwc_pkg::clamp_win(cfg.window_rows);
        wc_eff  = vwc_pkg::clamp_win(cfg.window_cols);
        col_p1  = {1'b0, col_reg} + vwc_pkg::DIM_W'(1);
        row_p1  = {1'b0, row_reg} + vwc_pkg::DIM_W'(1);
        emit    = (row_p1 >= vwc_pkg::DIM_W'(wr_eff)) && (col_p1 >= vwc_pkg::DIM_W'(wc_eff))
                  && (vwc_pkg::DIM_W'(wr_eff) <= h_eff) && (vwc_pkg::DIM_W'(wc_eff) <= w_eff);
        row_end = col_p1 >= w_eff;
        meta.last = (row_p1 >= h_eff) && row_end;
        meta.row  = row_reg - vwc_pkg::CNT_W'(wr_eff - vwc_pkg::WIN_W'(1));
        meta.col  = col_reg - vwc_pkg::CNT_W'(wc_eff - vwc_pkg::WIN_W'(1));
        if (row_end)
        begin
            col_next = '0;
            row_next = (row_p1 >= h_eff) ? '0 : row_p1[vwc_pkg::CNT_W-1:0];
        end
        else
        begin
            col_next = col_p1[vwc_pkg::CNT_W-1:0];
            row_next = row_reg;
        end
    end

    assign occupancy = {1'b0, q_count} + (vwc_pkg::QCNT_W + 1)'(s1_valid_reg && s1_emit_reg);
    assign full      = occupancy >= (vwc_pkg::QCNT_W + 1)'(vwc_pkg::QUEUE_DEPTH);
    assign accept    = push && !full;
    assign rd_addr   = vwc_pkg::ADDR_W'(col_reg);

    vwc_ram #(
        .WIDTH (vwc_pkg::LINE_W),
        .DEPTH (vwc_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // The previous sample's line store write lands on the same edge as this read.
    assign lines   = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign colv    = {s1_sample_reg, lines};
    assign wr_data = colv[vwc_pkg::MAX_WIN-1:1];

    always_comb
    begin
        for (int k = 0; k < vwc_pkg::MAX_WIN; k++)
        begin
            for (int l = 0; l < vwc_pkg::MAX_WIN - 1; l++)
            begin
                win_next[k][l] = win_reg[k][l+1];
            end
            win_next[k][vwc_pkg::MAX_WIN-1] = colv[k];
        end
    end

    assign q_push      = s1_valid_reg && s1_emit_reg;
    assign q_data.win  = win_next;
    assign q_data.meta = s1_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            byp_hit_reg  <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_emit_reg <= emit;
                byp_hit_reg <= s1_valid_reg && (s1_addr_reg == rd_addr);
            end
            if (s1_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_addr_reg   <= rd_addr;
            s1_meta_reg   <= meta;
            byp_data_reg  <= wr_data;
        end
    end

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(col_reg) && $stable(row_reg))
        else $error("raster counters moved without an input transfer");

endmodule

>>> rtl/vwc_queue.sv
// Short job queue between the front end and the multiply-accumulate back end.
module vwc_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  vwc_pkg::job_t              push_data,
    input  logic                       pop,
    output logic                       valid,
    output vwc_pkg::job_t              pop_data,
    output logic [vwc_pkg::QCNT_W-1:0] count
);

    vwc_pkg::job_t              slot_reg [vwc_pkg::QUEUE_DEPTH];
    logic [vwc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [vwc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [vwc_pkg::QCNT_W-1:0] count_reg;
    logic [vwc_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [vwc_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [vwc_pkg::QCNT_W-1:0] count_next;

    assign valid    = count_reg != '0;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == vwc_pkg::QPTR_W'(vwc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + vwc_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vwc_pkg::QPTR_W'(vwc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + vwc_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + vwc_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - vwc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != vwc_pkg::QCNT_W'(vwc_pkg::QUEUE_DEPTH))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("job queue read while empty");

endmodule

>>> rtl/vwc_back.sv
// Back end: coefficient alignment, products, adder tree and result register.
module vwc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vwc_pkg::cfg_t                     cfg,
    input  logic                              q_valid,
    input  vwc_pkg::job_t                     q_data,
    output logic                              q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [vwc_pkg::SUM_W-1:0]  out_sum,
    output logic [vwc_pkg::CNT_W-1:0]         out_row,
    output logic [vwc_pkg::CNT_W-1:0]         out_col,
    output logic                              out_last
);

    vwc_pkg::win_t               coef_reg;
    vwc_pkg::win_t               coef_next;
    logic [vwc_pkg::WIN_W-1:0]   off_r;
    logic [vwc_pkg::WIN_W-1:0]   off_c;

    logic                        p_valid_reg;
    logic [vwc_pkg::MAX_WIN-1:0][vwc_pkg::MAX_WIN-1:0][vwc_pkg::PROD_W-1:0] p_prod_reg;
    vwc_pkg::meta_t              p_meta_reg;
    logic                        s_valid_reg;
    logic [vwc_pkg::MAX_WIN-1:0][vwc_pkg::PART_W-1:0] s_part_reg;
    logic [vwc_pkg::MAX_WIN-1:0][vwc_pkg::PART_W-1:0] s_part_next;
    vwc_pkg::meta_t              s_meta_reg;
    logic                        o_valid_reg;
    logic signed [vwc_pkg::SUM_W-1:0] o_sum_reg;
    logic signed [vwc_pkg::SUM_W-1:0] o_sum_next;
    vwc_pkg::meta_t              o_meta_reg;

    logic                        o_ready;
    logic                        s_ready;
    logic                        p_ready;

    assign off_r = vwc_pkg::WIN_W'(vwc_pkg::MAX_WIN) - vwc_pkg::clamp_win(cfg.window_rows);
    assign off_c = vwc_pkg::WIN_W'(vwc_pkg::MAX_WIN) - vwc_pkg::clamp_win(cfg.window_cols);

    // Coefficient (k, l) lines up with window position (k + off_r, l + off_c).
    always_comb
    begin
        logic [vwc_pkg::WIN_W-1:0] ki;
        logic [vwc_pkg::WIN_W-1:0] lj;
        for (int i = 0; i < vwc_pkg::MAX_WIN; i++)
        begin
            for (int j = 0; j < vwc_pkg::MAX_WIN; j++)
            begin
                ki = vwc_pkg::WIN_W'(i) - off_r;
                lj = vwc_pkg::WIN_W'(j) - off_c;
                if ((vwc_pkg::WIN_W'(i) >= off_r) && (vwc_pkg::WIN_W'(j) >= off_c))
                begin
                    coef_next[i][j] = cfg.coef[ki][lj];
                end
                else
                begin
                    coef_next[i][j] = '0;
                end
            end
        end
    end

    assign o_ready = !o_valid_reg || pop;
    assign s_ready = !s_valid_reg || o_ready;
    assign p_ready = !p_valid_reg || s_ready;
    assign q_pop   = q_valid && p_ready;

    always_comb
    begin
        logic signed [vwc_pkg::PART_W-1:0] acc;
        for (int k = 0; k < vwc_pkg::MAX_WIN; k++)
        begin
            acc = '0;
            for (int l = 0; l < vwc_pkg::MAX_WIN; l++)
            begin
                acc = acc + vwc_pkg::PART_W'($signed(p_prod_reg[k][l]));
            end
            s_part_next[k] = acc;
        end
    end

    always_comb
    begin
        o_sum_next = '0;
        for (int k = 0; k < vwc_pkg::MAX_WIN; k++)
        begin
            o_sum_next = o_sum_next + vwc_pkg::SUM_W'($signed(s_part_reg[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= q_valid;
            end
            if (s_ready)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        if (q_pop)
        begin
            for (int i = 0; i < vwc_pkg::MAX_WIN; i++)
            begin
                for (int j = 0; j < vwc_pkg::MAX_WIN; j++)
                begin
                    p_prod_reg[i][j] <= $signed(coef_reg[i][j]) * $signed(q_data.win[i][j]);
                end
            end
            p_meta_reg <= q_data.meta;
        end
        if (s_ready && p_valid_reg)
        begin
            s_part_reg <= s_part_next;
            s_meta_reg <= p_meta_reg;
        end
        if (o_ready && s_valid_reg)
        begin
            o_sum_reg  <= o_sum_next;
            o_meta_reg <= s_meta_reg;
        end
    end

    assign empty    = !o_valid_reg;
    assign out_sum  = o_sum_reg;
    assign out_row  = o_meta_reg.row;
    assign out_col  = o_meta_reg.col;
    assign out_last = o_meta_reg.last;

endmodule

>>> rtl/valid_window_correlation_2d_unit.sv
// Top level of the valid-window 2D correlation unit: configuration registers and block wiring.
//
//  Channel   Signals                                  Transfer when
//  input     push, full, sample                       push & !full
//  result    empty, pop, out_sum/row/col/last         pop & !empty
//  config    cfg_write, cfg_index, cfg_data           cfg_write
//
// One sample is taken every cycle while full is low; a result passes through the line store
// read, the job queue, the product stage and the two-level adder tree to the result ports.
// Reset clears counters, window registers and the job queue; the line store is not cleared, so
// there is no start-up pass. When the result side stalls, the four-entry job queue fills
// and full rises; each side otherwise runs on its own.
module valid_window_correlation_2d_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [vwc_pkg::SAMPLE_W-1:0] sample,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [vwc_pkg::SUM_W-1:0]    out_sum,
    output logic [vwc_pkg::CNT_W-1:0]           out_row,
    output logic [vwc_pkg::CNT_W-1:0]           out_col,
    output logic                                out_last,
    input  logic                                cfg_write,
    input  logic [vwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vwc_pkg::COEF_ROW_W-1:0]      cfg_data
);

    vwc_pkg::cfg_t              cfg_reg;
    logic                       q_push;
    vwc_pkg::job_t              q_push_data;
    logic                       q_pop;
    logic                       q_valid;
    vwc_pkg::job_t              q_pop_data;
    logic [vwc_pkg::QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= vwc_pkg::DIM_W'(vwc_pkg::MAX_WIDTH);
            cfg_reg.image_height <= vwc_pkg::DIM_W'(vwc_pkg::MAX_HEIGHT);
            cfg_reg.window_rows  <= vwc_pkg::WIN_W'(vwc_pkg::MAX_WIN);
            cfg_reg.window_cols  <= vwc_pkg::WIN_W'(vwc_pkg::MAX_WIN);
            cfg_reg.coef         <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                vwc_pkg::REG_IMAGE_WIDTH:
                begin
                    cfg_reg.image_width <= cfg_data[vwc_pkg::DIM_W-1:0];
                end
                vwc_pkg::REG_IMAGE_HEIGHT:
                begin
                    cfg_reg.image_height <= cfg_data[vwc_pkg::DIM_W-1:0];
                end
                vwc_pkg::REG_WINDOW_ROWS:
                begin
                    cfg_reg.window_rows <= cfg_data[vwc_pkg::WIN_W-1:0];
                end
                vwc_pkg::REG_WINDOW_COLS:
                begin
                    cfg_reg.window_cols <= cfg_data[vwc_pkg::WIN_W-1:0];
                end
                vwc_pkg::REG_COEF_ROW0:
                begin
                    cfg_reg.coef[0] <= cfg_data;
                end
                vwc_pkg::REG_COEF_ROW1:
                begin
                    cfg_reg.coef[1] <= cfg_data;
                end
                vwc_pkg::REG_COEF_ROW2:
                begin
                    cfg_reg.coef[2] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    vwc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .sample  (sample),
        .full    (full),
        .q_count (q_count),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    vwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data),
        .count     (q_count)
    );

    vwc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_sum  (out_sum),
        .out_row  (out_row),
        .out_col  (out_col),
        .out_last (out_last)
    );

endmodule
